/* hdl/qau_pkg.sv */
// Shared definitions for the quaternion arithmetic unit.
// Holds operation codes, status codes, saturation limits and default settings.
// Depends on nothing.
`default_nettype none

package qau_pkg;

  // Default number of fraction bits in the fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Operation selector carried on the input tuser.
  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_HAM   = 3'd1,
    MODE_SCALE = 3'd2,
    MODE_CONJ  = 3'd3,
    MODE_MAG   = 3'd4,
    MODE_NORM  = 3'd5,
    MODE_INV   = 3'd6
  } mode_t;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  // Limits of a 32-bit signed component.
  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // Fields that travel along the whole pipeline.
  typedef struct packed {
    logic [2:0]       mode;
    logic [3:0][31:0] res;
    logic [1:0]       st;
    logic [3:0]       sgn;
    logic [3:0][31:0] mag;
  } car_t;

endpackage

`default_nettype wire

/* hdl/quaternion_arithmetic_unit.sv */
// Quaternion arithmetic unit, pipelined from input accept to output word.
// Throughput is one word per cycle while the output is not stalled; the
// pipeline length is set by the 33-stage square root and the FRAC_BITS + 1
// stages of the per-component divider.
// A stall at the output freezes every stage; rst_n (synchronous, active low)
// clears all stage valid bits, payload registers are not reset.
// Depends on qau_pkg.
`default_nettype none

module quaternion_arithmetic_unit #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, factor (32 bits each, from bit 0)
  input  wire logic [287:0] in_tdata,
  // mode
  input  wire logic [2:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // r_w, r_x, r_y, r_z (32 bits each, from bit 0)
  output logic [127:0]      out_tdata,
  // status
  output logic [1:0]        out_tuser
);

  localparam int NSQ = 33;
  localparam int QW  = FRAC_BITS + 1;
  localparam int LAT = 41 + FRAC_BITS;
  localparam logic [66:0] HALF = 67'(1) << (FRAC_BITS - 1);
  localparam logic signed [66:0] MAX67 = 67'sd2147483647;
  localparam logic signed [66:0] MIN67 = -67'sd2147483648;
  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

  typedef struct packed {
    qau_pkg::car_t    c;
    logic [3:0][31:0] a;
    logic [3:0][31:0] b;
    logic [3:0][31:0] d;
  } f1_t;

  typedef struct packed {
    qau_pkg::car_t         c;
    logic [3:0][3:0][63:0] p;
  } f2_t;

  typedef struct packed {
    qau_pkg::car_t         c;
    logic [3:0][1:0][64:0] pr;
  } f3_t;

  typedef struct packed {
    qau_pkg::car_t    c;
    logic [3:0][65:0] tot;
  } f4_t;

  typedef struct packed {
    qau_pkg::car_t c;
    logic [65:0]   s;
    logic [34:0]   rem;
    logic [32:0]   root;
  } sq_t;

  typedef struct packed {
    qau_pkg::car_t c;
    logic [32:0]   m;
  } rt_t;

  typedef struct packed {
    qau_pkg::car_t       c;
    logic [32:0]         m;
    logic [3:0][33:0]    rem;
    logic [3:0][QW-1:0]  q;
  } dv_t;

  logic            en;
  logic [LAT-1:0]  vld_r;
  f1_t             f1_r, f1_nxt;
  f2_t             f2_r, f2_nxt;
  f3_t             f3_r, f3_nxt;
  f4_t             f4_r, f4_nxt;
  sq_t             sq_r [0:NSQ];
  sq_t             sq0_nxt;
  rt_t             rt_r, rt_nxt;
  dv_t             dv_r [0:FRAC_BITS];
  dv_t             dv0_nxt;
  qau_pkg::car_t   o_r, o_nxt;

  logic [3:0][31:0]      a_in, b_in;
  logic [31:0]           f_in;
  logic [32:0]           sum33;
  logic [3:0][3:0][63:0] t;
  logic [66:0]           ext67;
  logic [66:0]           sh67;
  logic                  flag;

  // Sign extension of a pairwise sum by one bit.
  function automatic logic [65:0] f4_nxt_sx(input logic [64:0] v);
    f4_nxt_sx = {v[64], v};
  endfunction

  // The whole pipeline advances unless a finished word is held at the output.
  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;

  // Valid bits travel alongside the payload stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // Stage 1: unpack, quick results for add and conjugate, multiplier operands.
  always_comb begin
    f_in   = in_tdata[256 +: 32];
    f1_nxt = '0;
    sum33  = '0;
    f1_nxt.c.mode = in_tuser;
    f1_nxt.c.st   = qau_pkg::ST_OK;
    for (int i = 0; i < 4; i++) begin
      a_in[i] = in_tdata[32*i +: 32];
      b_in[i] = in_tdata[128 + 32*i +: 32];
    end
    f1_nxt.a = a_in;
    f1_nxt.b = b_in;
    for (int i = 0; i < 4; i++) begin
      // Sign and absolute value for normalize and inverse.
      f1_nxt.c.sgn[i] = a_in[i][31] ^ ((in_tuser == qau_pkg::MODE_INV) && (i > 0));
      f1_nxt.c.mag[i] = a_in[i][31] ? (32'd0 - a_in[i]) : a_in[i];
      case (in_tuser)
        qau_pkg::MODE_SCALE: f1_nxt.d[i] = f_in;
        qau_pkg::MODE_MAG,
        qau_pkg::MODE_NORM,
        qau_pkg::MODE_INV:   f1_nxt.d[i] = a_in[i];
        default:             f1_nxt.d[i] = b_in[i];
      endcase
      case (in_tuser)
        qau_pkg::MODE_ADD: begin
          sum33 = {a_in[i][31], a_in[i]} + {b_in[i][31], b_in[i]};
          if (sum33[32] != sum33[31]) begin
            f1_nxt.c.res[i] = sum33[32] ? qau_pkg::Q_MIN : qau_pkg::Q_MAX;
            f1_nxt.c.st     = qau_pkg::ST_SAT;
          end else begin
            f1_nxt.c.res[i] = sum33[31:0];
          end
        end
        qau_pkg::MODE_CONJ: begin
          if (i == 0) begin
            f1_nxt.c.res[i] = a_in[i];
          end else if (a_in[i] == qau_pkg::Q_MIN) begin
            f1_nxt.c.res[i] = qau_pkg::Q_MAX;
            f1_nxt.c.st     = qau_pkg::ST_SAT;
          end else begin
            f1_nxt.c.res[i] = 32'd0 - a_in[i];
          end
        end
        default: f1_nxt.c.res[i] = '0;
      endcase
    end
  end

  // Stage 2: sixteen exact 32 x 32 products; the diagonal takes the muxed operand.
  always_comb begin
    f2_nxt.c = f1_r.c;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        f2_nxt.p[i][j] = $signed({{32{f1_r.a[i][31]}}, f1_r.a[i]}) *
                         $signed((i == j) ? {{32{f1_r.d[i][31]}}, f1_r.d[i]}
                                          : {{32{f1_r.b[j][31]}}, f1_r.b[j]});
      end
    end
  end

  // Stage 3: signed terms of each row and pairwise sums.
  always_comb begin
    f3_nxt.c = f2_r.c;
    t        = '0;
    case (f2_r.c.mode)
      qau_pkg::MODE_HAM: begin
        t[0] = {64'd0 - f2_r.p[3][3], 64'd0 - f2_r.p[2][2],
                64'd0 - f2_r.p[1][1], f2_r.p[0][0]};
        t[1] = {64'd0 - f2_r.p[3][2], f2_r.p[2][3], f2_r.p[1][0], f2_r.p[0][1]};
        t[2] = {f2_r.p[3][1], f2_r.p[2][0], 64'd0 - f2_r.p[1][3], f2_r.p[0][2]};
        t[3] = {f2_r.p[3][0], 64'd0 - f2_r.p[2][1], f2_r.p[1][2], f2_r.p[0][3]};
      end
      qau_pkg::MODE_SCALE: begin
        for (int r = 0; r < 4; r++) begin
          t[r][0] = f2_r.p[r][r];
        end
      end
      qau_pkg::MODE_MAG,
      qau_pkg::MODE_NORM,
      qau_pkg::MODE_INV: begin
        t[0] = {f2_r.p[3][3], f2_r.p[2][2], f2_r.p[1][1], f2_r.p[0][0]};
      end
      default: t = '0;
    endcase
    for (int r = 0; r < 4; r++) begin
      f3_nxt.pr[r][0] = {t[r][0][63], t[r][0]} + {t[r][1][63], t[r][1]};
      f3_nxt.pr[r][1] = {t[r][2][63], t[r][2]} + {t[r][3][63], t[r][3]};
    end
  end

  // Stage 4: full row sums.
  always_comb begin
    f4_nxt.c = f3_r.c;
    for (int r = 0; r < 4; r++) begin
      f4_nxt.tot[r] = {f4_nxt_sx(f3_r.pr[r][0])} + {f4_nxt_sx(f3_r.pr[r][1])};
    end
  end

  // Stage 5: round and saturate products; sum of squares goes to the root.
  always_comb begin
    sq0_nxt      = '0;
    sq0_nxt.c    = f4_r.c;
    sq0_nxt.s    = {1'b0, f4_r.tot[0][64:0]};
    flag         = 1'b0;
    ext67        = '0;
    sh67         = '0;
    if ((f4_r.c.mode == qau_pkg::MODE_HAM) || (f4_r.c.mode == qau_pkg::MODE_SCALE)) begin
      for (int r = 0; r < 4; r++) begin
        ext67 = {f4_r.tot[r][65], f4_r.tot[r]} + HALF;
        sh67  = $signed(ext67) >>> FRAC_BITS;
        if ($signed(sh67) > MAX67) begin
          sq0_nxt.c.res[r] = qau_pkg::Q_MAX;
          flag             = 1'b1;
        end else if ($signed(sh67) < MIN67) begin
          sq0_nxt.c.res[r] = qau_pkg::Q_MIN;
          flag             = 1'b1;
        end else begin
          sq0_nxt.c.res[r] = sh67[31:0];
        end
      end
      sq0_nxt.c.st = flag ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
    end
  end

  // Front stage registers.
  always_ff @(posedge clk) begin
    if (en) begin
      f1_r     <= f1_nxt;
      f2_r     <= f2_nxt;
      f3_r     <= f3_nxt;
      f4_r     <= f4_nxt;
      sq_r[0]  <= sq0_nxt;
    end
  end

  // Square root, one result bit per stage.
  for (genvar k = 1; k <= NSQ; k++) begin : g_sqrt
    logic [36:0] remx;
    logic [36:0] trial;
    assign remx  = {sq_r[k-1].rem, sq_r[k-1].s[65:64]};
    assign trial = {2'b00, sq_r[k-1].root, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k].c <= sq_r[k-1].c;
        sq_r[k].s <= {sq_r[k-1].s[63:0], 2'b00};
        if (remx >= trial) begin
          sq_r[k].rem  <= 35'(remx - trial);
          sq_r[k].root <= {sq_r[k-1].root[31:0], 1'b1};
        end else begin
          sq_r[k].rem  <= remx[34:0];
          sq_r[k].root <= {sq_r[k-1].root[31:0], 1'b0};
        end
      end
    end
  end

  // Round the root to nearest; finish magnitude and the zero-magnitude case.
  always_comb begin
    rt_nxt.c = sq_r[NSQ].c;
    rt_nxt.m = sq_r[NSQ].root +
               33'(sq_r[NSQ].rem > {2'b00, sq_r[NSQ].root});
    case (sq_r[NSQ].c.mode)
      qau_pkg::MODE_MAG: begin
        if (rt_nxt.m > {1'b0, qau_pkg::Q_MAX}) begin
          rt_nxt.c.res[0] = qau_pkg::Q_MAX;
          rt_nxt.c.st     = qau_pkg::ST_SAT;
        end else begin
          rt_nxt.c.res[0] = rt_nxt.m[31:0];
          rt_nxt.c.st     = qau_pkg::ST_OK;
        end
      end
      qau_pkg::MODE_NORM,
      qau_pkg::MODE_INV: begin
        rt_nxt.c.st = (rt_nxt.m == '0) ? qau_pkg::ST_ZERO : qau_pkg::ST_OK;
      end
      default: rt_nxt.c.st = sq_r[NSQ].c.st;
    endcase
  end

  // First divider stage: the integer quotient bit (set only when |c| equals m).
  always_comb begin
    dv0_nxt.c = rt_r.c;
    dv0_nxt.m = rt_r.m;
    for (int i = 0; i < 4; i++) begin
      if ({1'b0, rt_r.c.mag[i]} >= rt_r.m) begin
        dv0_nxt.q[i]   = QW'(1);
        dv0_nxt.rem[i] = 34'({1'b0, rt_r.c.mag[i]} - rt_r.m);
      end else begin
        dv0_nxt.q[i]   = '0;
        dv0_nxt.rem[i] = {2'b00, rt_r.c.mag[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt_r     <= rt_nxt;
      dv_r[0]  <= dv0_nxt;
    end
  end

  // Restoring division of each component by the magnitude, one fraction bit a stage.
  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_div
    logic [3:0][33:0] rem2;
    logic [3:0]       ge;
    always_comb begin
      for (int i = 0; i < 4; i++) begin
        rem2[i] = {dv_r[k-1].rem[i][32:0], 1'b0};
        ge[i]   = rem2[i] >= {1'b0, dv_r[k-1].m};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k].c <= dv_r[k-1].c;
        dv_r[k].m <= dv_r[k-1].m;
        for (int i = 0; i < 4; i++) begin
          dv_r[k].rem[i] <= ge[i] ? (rem2[i] - {1'b0, dv_r[k-1].m}) : rem2[i];
          dv_r[k].q[i]   <= {dv_r[k-1].q[i][QW-2:0], ge[i]};
        end
      end
    end
  end

  // Final rounding half away from zero and sign for normalize and inverse.
  always_comb begin
    logic [31:0] qr;
    o_nxt = dv_r[FRAC_BITS].c;
    qr    = '0;
    if (((o_nxt.mode == qau_pkg::MODE_NORM) || (o_nxt.mode == qau_pkg::MODE_INV)) &&
        (dv_r[FRAC_BITS].m != '0)) begin
      for (int i = 0; i < 4; i++) begin
        qr = 32'(dv_r[FRAC_BITS].q[i]) +
             32'({dv_r[FRAC_BITS].rem[i], 1'b0} >= {2'b00, dv_r[FRAC_BITS].m});
        o_nxt.res[i] = o_nxt.sgn[i] ? (32'd0 - qr) : qr;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      o_r <= o_nxt;
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = o_r.res;
  assign out_tuser  = o_r.st;

  // A zero-magnitude status comes with an all-zero word.
  a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == qau_pkg::ST_ZERO)) |-> (out_tdata == '0))
    else $error("zero-magnitude status with nonzero components");

  // Magnitude mode leaves x, y and z at zero.
  a_mag_xyz: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (o_r.mode == qau_pkg::MODE_MAG)) |-> (o_r.res[3:1] == '0))
    else $error("magnitude result with nonzero vector part");

  // A normalized w component never exceeds one in magnitude.
  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (o_r.mode == qau_pkg::MODE_NORM)) |->
      (($signed(o_r.res[0]) <= ONE_Q) && ($signed(o_r.res[0]) >= -ONE_Q)))
    else $error("normalized w component out of range");

  // An accepted word enters the first stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted word lost at pipeline entry");

endmodule

`default_nettype wire
